@@ sv/sas_pkg.sv @@
// Shared types and constants of the sprite animation sequencer.
package sas_pkg;

  localparam int MAX_LOOPS  = 8;
  localparam int MAX_FRAMES = 16;

  localparam int LoopIdxW  = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
  localparam int FrameIdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RamDepth  = MAX_LOOPS * MAX_FRAMES;
  localparam int AddrW     = (RamDepth > 1) ? $clog2(RamDepth) : 1;
  localparam int CntW      = $clog2(MAX_FRAMES + 1);

  localparam int TimeW = 16;
  localparam int SumW  = TimeW + 1;
  localparam int BitW  = $clog2(SumW);
  localparam int FnumW = 11;
  localparam int LenW  = 5;

  typedef logic signed [FnumW-1:0] frame_num_t;
  typedef logic [TimeW-1:0]        time_t;
  typedef logic [SumW-1:0]         sum_t;
  typedef logic [AddrW-1:0]        addr_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_LOOP   = 2'd2,
    CMD_FRAME  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK_CHK,
    S_DIV,
    S_FETCH,
    S_SRCH,
    S_SEL_TAKE,
    S_OUT
  } state_t;

  typedef struct packed {
    frame_num_t num;
    time_t      start;
  } frame_entry_t;

  typedef struct packed {
    logic         we;
    addr_t        waddr;
    frame_entry_t wdata;
    addr_t        raddr;
  } ram_req_t;

  typedef struct packed {
    logic ge;
    sum_t diff;
  } cmp_res_t;

endpackage

@@ sv/sas_if.sv @@
// Handshake channel interfaces for commands and results.
interface sas_in_if;
  logic                valid;
  logic                ready;
  sas_pkg::cmd_t       command;
  logic [15:0]         delta_ms;
  logic [2:0]          loop_index;
  logic                force_restart;
  logic [3:0]          frame_index;
  sas_pkg::frame_num_t frame_number;
  logic [15:0]         frame_start;
  logic [4:0]          loop_length;
  logic [15:0]         loop_duration;
  logic                loop_repeats;

  modport source (
    output valid, command, delta_ms, loop_index, force_restart, frame_index,
           frame_number, frame_start, loop_length, loop_duration, loop_repeats,
    input  ready
  );
  modport sink (
    input  valid, command, delta_ms, loop_index, force_restart, frame_index,
           frame_number, frame_start, loop_length, loop_duration, loop_repeats,
    output ready
  );
endinterface

interface sas_out_if;
  logic                valid;
  logic                ready;
  sas_pkg::frame_num_t current_frame;
  logic                loop_ended;
  logic [15:0]         elapsed_ms;

  modport source (output valid, current_frame, loop_ended, elapsed_ms, input ready);
  modport sink (input valid, current_frame, loop_ended, elapsed_ms, output ready);
endinterface

@@ sv/sas_cmpsub.sv @@
// Shared compare and subtract unit for wrap, remainder steps and frame search.
module sas_cmpsub (
  input  sas_pkg::sum_t     a,
  input  sas_pkg::sum_t     b,
  output sas_pkg::cmp_res_t res
);

  logic [sas_pkg::SumW:0] full;

  assign full     = {1'b0, a} - {1'b0, b};
  assign res.diff = full[sas_pkg::SumW-1:0];
  assign res.ge   = ~full[sas_pkg::SumW];

endmodule

@@ sv/sas_frame_ram.sv @@
// Frame entry memory: one write port, one registered read port.
module sas_frame_ram (
  input  logic                  clk,
  input  sas_pkg::ram_req_t     req,
  output sas_pkg::frame_entry_t rdata
);

  sas_pkg::frame_entry_t mem [sas_pkg::RamDepth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ sv/sprite_animation_sequencer.sv @@
// Sprite animation sequencer top level: control sequencer and state registers.
// Steps per command: write EXEC, OUT; select EXEC, SEL_TAKE if it changes or restarts
// the loop, OUT; tick EXEC, TICK_CHK, DIV when the time wraps (one remainder bit per
// cycle in the shared compare unit), FETCH, SRCH across the entries passed (at most MAX_FRAMES), OUT.
// One command at a time; the next is taken the cycle after the result is taken.
// Synchronous active-low reset clears loop, time and frame; tables are undefined.
module sprite_animation_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  sas_in_if.sink    in_ch,
  sas_out_if.source out_ch
);

  sas_pkg::state_t state_r, state_nxt;

  sas_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [2:0]          lp_r, lp_nxt;
  logic                force_r, force_nxt;
  logic [3:0]          fi_r, fi_nxt;
  sas_pkg::frame_num_t fnum_r, fnum_nxt;
  sas_pkg::time_t      fstart_r, fstart_nxt;
  logic [4:0]          llen_r, llen_nxt;
  sas_pkg::time_t      ldur_r, ldur_nxt;
  logic                lrep_r, lrep_nxt;

  sas_pkg::sum_t              time_r, time_nxt;
  sas_pkg::time_t             rem_r, rem_nxt;
  logic [sas_pkg::BitW-1:0]   bit_r, bit_nxt;
  logic [sas_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  sas_pkg::frame_num_t        prev_num_r, prev_num_nxt;
  logic                       ended_r, ended_nxt;
  logic [2:0]                 cur_loop_r, cur_loop_nxt;
  sas_pkg::time_t             elapsed_r, elapsed_nxt;
  sas_pkg::frame_num_t        shown_r, shown_nxt;

  logic [4:0]     len_tab [sas_pkg::MAX_LOOPS];
  sas_pkg::time_t dur_tab [sas_pkg::MAX_LOOPS];
  logic           rep_tab [sas_pkg::MAX_LOOPS];

  logic [sas_pkg::LoopIdxW-1:0] cur_idx, lp_idx;
  logic [sas_pkg::CntW-1:0]     len_eff;
  logic [4:0]                   cur_len;
  sas_pkg::time_t               cur_dur;
  logic                         cur_rep;
  logic                         lp_ok, fi_ok, sel_go, wrap, srch_done;

  sas_pkg::ram_req_t     ram_req;
  sas_pkg::frame_entry_t ram_rdata;
  sas_pkg::sum_t         cmp_a, cmp_b;
  sas_pkg::cmp_res_t     cmp_res;
  sas_pkg::sum_t         div_a;
  logic                  in_fire, out_fire;

  sas_cmpsub u_cmpsub (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  sas_frame_ram u_frame_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign cur_idx = sas_pkg::LoopIdxW'(cur_loop_r);
  assign lp_idx  = sas_pkg::LoopIdxW'(lp_r);
  assign cur_len = len_tab[cur_idx];
  assign cur_dur = dur_tab[cur_idx];
  assign cur_rep = rep_tab[cur_idx];
  assign len_eff = (int'(cur_len) > sas_pkg::MAX_FRAMES) ?
                   sas_pkg::CntW'(sas_pkg::MAX_FRAMES) : sas_pkg::CntW'(cur_len);

  assign lp_ok  = int'(lp_r) < sas_pkg::MAX_LOOPS;
  assign fi_ok  = int'(fi_r) < sas_pkg::MAX_FRAMES;
  assign sel_go = lp_ok && ((lp_r != cur_loop_r) || force_r);
  assign div_a  = {rem_r, time_r[bit_r]};
  assign wrap   = cur_rep && (cur_dur != '0) && cmp_res.ge;
  assign srch_done = !((cnt_r < len_eff) && cmp_res.ge);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sas_pkg::S_IDLE:     if (in_fire) state_nxt = sas_pkg::S_EXEC;
      sas_pkg::S_EXEC: begin
        unique case (cmd_r)
          sas_pkg::CMD_TICK:   state_nxt = sas_pkg::S_TICK_CHK;
          sas_pkg::CMD_SELECT: state_nxt = sel_go ? sas_pkg::S_SEL_TAKE : sas_pkg::S_OUT;
          sas_pkg::CMD_LOOP:   state_nxt = sas_pkg::S_OUT;
          sas_pkg::CMD_FRAME:  state_nxt = sas_pkg::S_OUT;
        endcase
      end
      sas_pkg::S_TICK_CHK: state_nxt = wrap ? sas_pkg::S_DIV : sas_pkg::S_FETCH;
      sas_pkg::S_DIV:      if (bit_r == '0) state_nxt = sas_pkg::S_FETCH;
      sas_pkg::S_FETCH:    state_nxt = sas_pkg::S_SRCH;
      sas_pkg::S_SRCH:     if (srch_done) state_nxt = sas_pkg::S_OUT;
      sas_pkg::S_SEL_TAKE: state_nxt = sas_pkg::S_OUT;
      sas_pkg::S_OUT:      if (out_fire) state_nxt = sas_pkg::S_IDLE;
      default:             state_nxt = sas_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = (state_r == sas_pkg::S_IDLE);
    out_ch.valid  = (state_r == sas_pkg::S_OUT);
    ram_req.we    = (state_r == sas_pkg::S_EXEC) && (cmd_r == sas_pkg::CMD_FRAME)
                    && lp_ok && fi_ok;
    ram_req.waddr = sas_pkg::AddrW'(sas_pkg::AddrW'(lp_idx) * sas_pkg::AddrW'(sas_pkg::MAX_FRAMES)
                    + sas_pkg::AddrW'(fi_r));
    ram_req.wdata = '{num: fnum_r, start: fstart_r};
    ram_req.raddr = sas_pkg::AddrW'(sas_pkg::AddrW'(cur_idx) *
                    sas_pkg::AddrW'(sas_pkg::MAX_FRAMES));
    cmp_a = time_r;
    cmp_b = {1'b0, cur_dur};
    unique case (state_r)
      sas_pkg::S_EXEC: begin
        ram_req.raddr = sas_pkg::AddrW'(sas_pkg::AddrW'(lp_idx) *
                        sas_pkg::AddrW'(sas_pkg::MAX_FRAMES));
      end
      sas_pkg::S_DIV: begin
        cmp_a = div_a;
      end
      sas_pkg::S_SRCH: begin
        cmp_b = {1'b0, ram_rdata.start};
        ram_req.raddr = sas_pkg::AddrW'(sas_pkg::AddrW'(cur_idx) *
                        sas_pkg::AddrW'(sas_pkg::MAX_FRAMES)
                        + sas_pkg::AddrW'(sas_pkg::FrameIdxW'(cnt_r + 1'b1)));
      end
      default: begin
      end
    endcase
  end

  assign out_ch.current_frame = shown_r;
  assign out_ch.loop_ended    = ended_r;
  assign out_ch.elapsed_ms    = elapsed_r;

  always_comb begin
    cmd_nxt      = cmd_r;
    lp_nxt       = lp_r;
    force_nxt    = force_r;
    fi_nxt       = fi_r;
    fnum_nxt     = fnum_r;
    fstart_nxt   = fstart_r;
    llen_nxt     = llen_r;
    ldur_nxt     = ldur_r;
    lrep_nxt     = lrep_r;
    time_nxt     = time_r;
    rem_nxt      = rem_r;
    bit_nxt      = bit_r;
    cnt_nxt      = cnt_r;
    prev_num_nxt = prev_num_r;
    ended_nxt    = ended_r;
    cur_loop_nxt = cur_loop_r;
    elapsed_nxt  = elapsed_r;
    shown_nxt    = shown_r;
    unique case (state_r)
      sas_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = in_ch.command;
          lp_nxt     = in_ch.loop_index;
          force_nxt  = in_ch.force_restart;
          fi_nxt     = in_ch.frame_index;
          fnum_nxt   = in_ch.frame_number;
          fstart_nxt = in_ch.frame_start;
          llen_nxt   = in_ch.loop_length;
          ldur_nxt   = in_ch.loop_duration;
          lrep_nxt   = in_ch.loop_repeats;
          time_nxt   = {1'b0, elapsed_r} + {1'b0, in_ch.delta_ms};
          ended_nxt  = 1'b0;
        end
      end
      sas_pkg::S_TICK_CHK: begin
        ended_nxt = !cur_rep && cmp_res.ge;
        rem_nxt   = '0;
        bit_nxt   = sas_pkg::BitW'(sas_pkg::SumW - 1);
      end
      sas_pkg::S_DIV: begin
        rem_nxt = cmp_res.ge ? cmp_res.diff[sas_pkg::TimeW-1:0] : div_a[sas_pkg::TimeW-1:0];
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          time_nxt = {1'b0, rem_nxt};
        end
      end
      sas_pkg::S_FETCH: begin
        cnt_nxt = '0;
      end
      sas_pkg::S_SRCH: begin
        if (!srch_done) begin
          cnt_nxt      = cnt_r + 1'b1;
          prev_num_nxt = ram_rdata.num;
        end else begin
          shown_nxt = (cnt_r == '0) ? ram_rdata.num : prev_num_r;
          if (ended_r) begin
            elapsed_nxt = cur_dur;
          end else begin
            elapsed_nxt = time_r[sas_pkg::TimeW] ? '1 : time_r[sas_pkg::TimeW-1:0];
          end
        end
      end
      sas_pkg::S_SEL_TAKE: begin
        shown_nxt    = ram_rdata.num;
        cur_loop_nxt = lp_r;
        elapsed_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sas_pkg::S_IDLE;
      cur_loop_r <= '0;
      elapsed_r  <= '0;
      shown_r    <= '0;
      ended_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_loop_r <= cur_loop_nxt;
      elapsed_r  <= elapsed_nxt;
      shown_r    <= shown_nxt;
      ended_r    <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    lp_r       <= lp_nxt;
    force_r    <= force_nxt;
    fi_r       <= fi_nxt;
    fnum_r     <= fnum_nxt;
    fstart_r   <= fstart_nxt;
    llen_r     <= llen_nxt;
    ldur_r     <= ldur_nxt;
    lrep_r     <= lrep_nxt;
    time_r     <= time_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    cnt_r      <= cnt_nxt;
    prev_num_r <= prev_num_nxt;
  end

  always_ff @(posedge clk) begin
    if ((state_r == sas_pkg::S_EXEC) && (cmd_r == sas_pkg::CMD_LOOP) && lp_ok) begin
      len_tab[lp_idx] <= llen_r;
      dur_tab[lp_idx] <= ldur_r;
      rep_tab[lp_idx] <= lrep_r;
    end
  end

endmodule

@@ tb/sprite_animation_sequencer_test.sv @@
// Self-checking testbench for the sprite animation sequencer with a built-in timeline predictor.
module sprite_animation_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalItems  = 1550;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 60;
  localparam int StallCycles = 600;
  localparam int StallAfter  = 400;

  typedef struct packed {
    sas_pkg::cmd_t                 command;
    logic [sas_pkg::TimeW-1:0]     delta_ms;
    logic [sas_pkg::LoopIdxW-1:0]  loop_index;
    logic                          force_restart;
    logic [sas_pkg::FrameIdxW-1:0] frame_index;
    sas_pkg::frame_num_t           frame_number;
    logic [sas_pkg::TimeW-1:0]     frame_start;
    logic [sas_pkg::LenW-1:0]      loop_length;
    logic [sas_pkg::TimeW-1:0]     loop_duration;
    logic                          loop_repeats;
  } anim_cmd_t;

  typedef struct packed {
    sas_pkg::frame_num_t frame;
    logic                ended;
    sas_pkg::time_t      elapsed;
  } anim_result_t;

  class frame_timeline_sb;
    logic [sas_pkg::LenW-1:0]     loop_len [sas_pkg::MAX_LOOPS];
    sas_pkg::time_t               loop_dur [sas_pkg::MAX_LOOPS];
    logic                         loop_wraps [sas_pkg::MAX_LOOPS];
    sas_pkg::frame_num_t          entry_num [sas_pkg::RamDepth];
    sas_pkg::time_t               entry_start [sas_pkg::RamDepth];
    logic [sas_pkg::LoopIdxW-1:0] cur_loop;
    sas_pkg::time_t               run_ms;
    sas_pkg::frame_num_t          shown;
    anim_result_t                 pending_q [$];
    int                           mismatches;

    function new();
      cur_loop   = '0;
      run_ms     = '0;
      shown      = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function sas_pkg::frame_num_t search_frame(int lp, sas_pkg::sum_t t);
      int n;
      int i;
      int base;
      n = loop_len[lp];
      if (n > sas_pkg::MAX_FRAMES) n = sas_pkg::MAX_FRAMES;
      base = lp * sas_pkg::MAX_FRAMES;
      i = 0;
      while (i < n && sas_pkg::sum_t'(entry_start[base + i]) <= t) i++;
      return (i == 0) ? entry_num[base] : entry_num[base + i - 1];
    endfunction

    function void note_command(anim_cmd_t c);
      sas_pkg::sum_t  total;
      sas_pkg::time_t dur;
      int             idx;
      anim_result_t   res;
      res.ended = 1'b0;
      case (c.command)
        sas_pkg::CMD_TICK: begin
          dur   = loop_dur[cur_loop];
          total = sas_pkg::sum_t'(run_ms) + sas_pkg::sum_t'(c.delta_ms);
          if (loop_wraps[cur_loop] && dur != 0 && total >= sas_pkg::sum_t'(dur)) begin
            total = total % dur;
          end
          shown = search_frame(cur_loop, total);
          if (!loop_wraps[cur_loop] && total >= sas_pkg::sum_t'(dur)) begin
            run_ms    = dur;
            res.ended = 1'b1;
          end else begin
            run_ms = (total > sas_pkg::sum_t'(16'hFFFF)) ? 16'hFFFF
                                                        : total[sas_pkg::TimeW-1:0];
          end
        end
        sas_pkg::CMD_SELECT: begin
          if (int'(c.loop_index) < sas_pkg::MAX_LOOPS &&
              (c.loop_index != cur_loop || c.force_restart)) begin
            cur_loop = c.loop_index;
            shown    = entry_num[int'(c.loop_index) * sas_pkg::MAX_FRAMES];
            run_ms   = '0;
          end
        end
        sas_pkg::CMD_LOOP: begin
          if (int'(c.loop_index) < sas_pkg::MAX_LOOPS) begin
            loop_len[c.loop_index]   = c.loop_length;
            loop_dur[c.loop_index]   = c.loop_duration;
            loop_wraps[c.loop_index] = c.loop_repeats;
          end
        end
        default: begin
          if (int'(c.loop_index) < sas_pkg::MAX_LOOPS &&
              int'(c.frame_index) < sas_pkg::MAX_FRAMES) begin
            idx              = int'(c.loop_index) * sas_pkg::MAX_FRAMES + int'(c.frame_index);
            entry_num[idx]   = c.frame_number;
            entry_start[idx] = c.frame_start;
          end
        end
      endcase
      res.frame   = shown;
      res.elapsed = run_ms;
      pending_q.push_back(res);
    endfunction

    function void check_result(sas_pkg::frame_num_t frame, logic ended,
                               sas_pkg::time_t elapsed);
      anim_result_t exp_r;
      if (pending_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result frame %0d ended %0b elapsed %0d",
                                $signed(frame), ended, elapsed));
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r.frame !== frame || exp_r.ended !== ended || exp_r.elapsed !== elapsed)
        note_mismatch($sformatf({"expected frame %0d ended %0b elapsed %0d, ",
                                 "got frame %0d ended %0b elapsed %0d"},
                                $signed(exp_r.frame), exp_r.ended, exp_r.elapsed,
                                $signed(frame), ended, elapsed));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sas_in_if  in_ch ();
  sas_out_if out_ch ();

  sprite_animation_sequencer u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frame_timeline_sb timeline;
  int               items_sent;
  int               results_seen;
  int               burst_left;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return $urandom_range(sas_pkg::MAX_FRAMES + 1, 31);
    return $urandom_range(1, sas_pkg::MAX_FRAMES);
  endfunction

  function automatic int pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 18) return $urandom_range(0, 65535);
    return $urandom_range(50, 4000);
  endfunction

  function automatic int pick_frame_number();
    return ($urandom_range(0, 19) == 0) ? -1 : $urandom_range(0, 1023);
  endfunction

  function automatic anim_cmd_t noise_cmd(sas_pkg::cmd_t op);
    anim_cmd_t c;
    c.command       = op;
    c.delta_ms      = 16'($urandom);
    c.loop_index    = sas_pkg::LoopIdxW'($urandom);
    c.force_restart = 1'($urandom);
    c.frame_index   = sas_pkg::FrameIdxW'($urandom);
    c.frame_number  = sas_pkg::frame_num_t'(pick_frame_number());
    c.frame_start   = 16'($urandom);
    c.loop_length   = sas_pkg::LenW'($urandom);
    c.loop_duration = 16'($urandom);
    c.loop_repeats  = 1'($urandom);
    return c;
  endfunction

  task automatic send_cmd(input anim_cmd_t c);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= c.command;
    in_ch.delta_ms      <= c.delta_ms;
    in_ch.loop_index    <= c.loop_index;
    in_ch.force_restart <= c.force_restart;
    in_ch.frame_index   <= c.frame_index;
    in_ch.frame_number  <= c.frame_number;
    in_ch.frame_start   <= c.frame_start;
    in_ch.loop_length   <= c.loop_length;
    in_ch.loop_duration <= c.loop_duration;
    in_ch.loop_repeats  <= c.loop_repeats;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    timeline.note_command(c);
    items_sent++;
  endtask

  task automatic write_loop(int lp, int len, int dur, bit rep);
    anim_cmd_t c;
    c = noise_cmd(sas_pkg::CMD_LOOP);
    c.loop_index    = sas_pkg::LoopIdxW'(lp);
    c.loop_length   = sas_pkg::LenW'(len);
    c.loop_duration = 16'(dur);
    c.loop_repeats  = rep;
    send_cmd(c);
  endtask

  task automatic write_frame(int lp, int fi, int num, int start);
    anim_cmd_t c;
    c = noise_cmd(sas_pkg::CMD_FRAME);
    c.loop_index   = sas_pkg::LoopIdxW'(lp);
    c.frame_index  = sas_pkg::FrameIdxW'(fi);
    c.frame_number = sas_pkg::frame_num_t'(num);
    c.frame_start  = 16'(start);
    send_cmd(c);
  endtask

  task automatic tick(int delta);
    anim_cmd_t c;
    c = noise_cmd(sas_pkg::CMD_TICK);
    c.delta_ms = 16'(delta);
    send_cmd(c);
  endtask

  task automatic select_loop(int lp, bit restart);
    anim_cmd_t c;
    c = noise_cmd(sas_pkg::CMD_SELECT);
    c.loop_index    = sas_pkg::LoopIdxW'(lp);
    c.force_restart = restart;
    send_cmd(c);
  endtask

  // rewrite a whole loop with mostly ascending start times
  task automatic fill_loop(int lp);
    int dur;
    int step;
    int acc;
    int start;
    dur  = pick_duration();
    write_loop(lp, pick_length(), dur, 1'($urandom));
    step = ((dur == 0) ? 4000 : dur) / sas_pkg::MAX_FRAMES + 1;
    acc  = 0;
    for (int fi = 0; fi < sas_pkg::MAX_FRAMES; fi++) begin
      if ($urandom_range(0, 7) == 0) begin
        start = $urandom_range(0, 65535);
      end else begin
        start = (acc > 65535) ? 65535 : acc;
        acc += $urandom_range(0, 2 * step);
      end
      write_frame(lp, fi, pick_frame_number(), start);
    end
  endtask

  task automatic random_item();
    int r;
    int s;
    int d;
    int lp;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      d = timeline.loop_dur[timeline.cur_loop];
      s = $urandom_range(0, 9);
      if (s < 7) tick($urandom_range(0, d / 4 + 20));
      else if (s < 9) tick($urandom_range(0, d + d / 2 + 1));
      else tick(($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(0, 65535));
    end else if (r < 67) begin
      select_loop($urandom_range(0, sas_pkg::MAX_LOOPS - 1), $urandom_range(0, 2) == 0);
    end else if (r < 75) begin
      write_loop($urandom_range(0, sas_pkg::MAX_LOOPS - 1), pick_length(), pick_duration(),
                 1'($urandom));
    end else if (r < 95) begin
      lp = $urandom_range(0, sas_pkg::MAX_LOOPS - 1);
      s  = $urandom_range(0, sas_pkg::MAX_FRAMES - 1);
      d  = timeline.loop_dur[lp];
      if ($urandom_range(0, 3) == 0) d = $urandom_range(0, 65535);
      else d = (d * s) / sas_pkg::MAX_FRAMES + $urandom_range(0, 50);
      write_frame(lp, s, pick_frame_number(), (d > 65535) ? 65535 : d);
    end else begin
      lp = $urandom_range(0, sas_pkg::MAX_LOOPS - 1);
      fill_loop(lp);
      select_loop(lp, 1'b1);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      timeline.check_result(out_ch.current_frame, out_ch.loop_ended, out_ch.elapsed_ms);
      results_seen++;
    end
  end

  initial begin
    bit stalled;
    int gap;
    stalled = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!stalled && results_seen >= StallAfter) begin
        stalled = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (StallCycles) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("sprite_animation_sequencer_test: errors");
    $finish;
  end

  initial begin
    timeline            = new();
    items_sent          = 0;
    results_seen        = 0;
    burst_left          = 0;
    rst_n               = 1'b0;
    out_ch.ready        = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = sas_pkg::CMD_TICK;
    in_ch.delta_ms      = '0;
    in_ch.loop_index    = '0;
    in_ch.force_restart = 1'b0;
    in_ch.frame_index   = '0;
    in_ch.frame_number  = '0;
    in_ch.frame_start   = '0;
    in_ch.loop_length   = '0;
    in_ch.loop_duration = '0;
    in_ch.loop_repeats  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int lp = 0; lp < sas_pkg::MAX_LOOPS; lp++) fill_loop(lp);

    write_loop(0, 4, 1000, 1'b1);
    write_frame(0, 0, 0, 100);
    write_frame(0, 1, 1023, 250);
    write_frame(0, 2, -1, 500);
    write_frame(0, 3, 5, 750);
    select_loop(0, 1'b1);
    tick(50);
    tick(200);
    tick(900);
    tick(65535);
    select_loop(0, 1'b0);
    write_loop(1, 16, 0, 1'b1);
    write_frame(1, 15, 1023, 65535);
    select_loop(1, 1'b0);
    tick(65535);
    tick(65535);
    write_loop(2, 31, 3000, 1'b0);
    select_loop(2, 1'b0);
    tick(2999);
    tick(1);
    tick(65535);
    write_loop(3, 16, 0, 1'b0);
    select_loop(3, 1'b1);
    tick(0);
    write_loop(4, 0, 500, 1'b1);
    select_loop(4, 1'b1);
    tick(700);

    while (items_sent < TotalItems) random_item();
    in_ch.valid <= 1'b0;

    while (timeline.pending() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (timeline.mismatches == 0)
      $display("sprite_animation_sequencer_test: clean");
    else
      $display("sprite_animation_sequencer_test: errors");
    $finish;
  end

endmodule
